FILE: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the streaming top-K selector
// Holds the store depth, field widths, the cell entry and control types
// and the controller state encoding.
// ----------------------------------------------------------------------------
package tks_pkg;

    // Number of kept values (store depth).
    localparam int TOP_COUNT = 8;

    // Field widths.
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 3;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - RANK_W;

    // Width of the drain counter; at least one bit.
    localparam int CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    // One stored entry of the chain.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } tks_entry_t;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic offer_en;  // a new value is offered to the chain
        logic drain_en;  // all entries move one place toward rank zero
    } tks_cell_ctrl_t;

    // Controller states.
    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } tks_state_t;

endpackage

FILE: rtl/streaming_top_k_selector_unit.sv
// ----------------------------------------------------------------------------
// streaming_top_k_selector_unit: keeps the TOP_COUNT largest signed values
// Timing: an ordinary value is registered into the chain as it is accepted; the first
// result of a set appears in the cycle after its last value is accepted.
// Throughput: one value per cycle while collecting; a set end costs TOP_COUNT
// output beats, during which no input is taken, set by the shared drain path.
// Reset: asynchronous, clears the store and returns to collecting.
// ----------------------------------------------------------------------------
module streaming_top_k_selector_unit
    import tks_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                 s_tlast,  // end_of_set
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [31:0] top_value, [34:32] rank, [39:35] zero
    output logic [0:0]           m_tuser,  // [0] rank_valid
    output logic                 m_tlast   // last_result
);

    tks_state_t      state_reg;
    tks_state_t      state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    tks_cell_ctrl_t  ctrl;
    logic            in_fire;
    logic            out_fire;
    logic            last_beat;

    tks_entry_t      entries [TOP_COUNT];
    logic            takes   [TOP_COUNT];

    // Handshakes.
    assign s_tready  = (state_reg == ST_COLLECT);
    assign m_tvalid  = (state_reg == ST_DRAIN);
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign last_beat = (cnt_reg == CNT_W'(TOP_COUNT - 1));

    assign ctrl.offer_en = in_fire;
    assign ctrl.drain_en = out_fire;

    // Chain of cells, rank zero first.
    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        tks_entry_t prev_e;
        tks_entry_t next_e;
        logic       prev_t;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_t = 1'b0;
        end
        else
        begin : g_inner
            assign prev_e = entries[i-1];
            assign prev_t = takes[i-1];
        end

        if (i == TOP_COUNT - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_body
            assign next_e = entries[i+1];
        end

        tks_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .offer_value (s_tdata[VALUE_W-1:0]),
            .prev_take   (prev_t),
            .prev_entry  (prev_e),
            .next_entry  (next_e),
            .take        (takes[i]),
            .entry       (entries[i])
        );
    end

    // Controller next state and drain counters.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                    rank_next  = '0;
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    rank_next = rank_reg + RANK_W'(1);
                    if (last_beat)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rank_reg  <= rank_next;
        end
    end

    // Result beat comes from rank zero of the chain.
    assign m_tdata = {{M_PAD_W{1'b0}}, rank_reg,
                      entries[0].valid ? entries[0].value : {VALUE_W{1'b0}}};
    assign m_tuser = entries[0].valid;
    assign m_tlast = last_beat;

endmodule

FILE: rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one rank of the top-K insertion chain
// Holds one entry. On an offered value it keeps its entry, takes the new
// value, or takes its upper neighbor's entry; while draining it takes its
// lower neighbor's entry.
// ----------------------------------------------------------------------------
module tks_cell
    import tks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tks_cell_ctrl_t     ctrl,
    input  logic [VALUE_W-1:0] offer_value,
    input  logic               prev_take,
    input  tks_entry_t         prev_entry,
    input  tks_entry_t         next_entry,
    output logic               take,
    output tks_entry_t         entry
);

    tks_entry_t entry_reg;
    tks_entry_t entry_next;

    // The offered value belongs at or above this rank when the rank is empty
    // or holds a strictly smaller value.
    assign take = !entry_reg.valid ||
                  ($signed(offer_value) > $signed(entry_reg.value));

    // Next entry selection.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.drain_en)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.offer_en)
        begin
            if (prev_take)
            begin
                entry_next = prev_entry;
            end
            else if (take)
            begin
                entry_next.valid = 1'b1;
                entry_next.value = offer_value;
            end
        end
    end

    // Entry register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker: port-level checks for the streaming top-K selector
// Watches the top level's ports and flags ordering and drain slips.
// ----------------------------------------------------------------------------
module tks_checker
    import tks_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast
);

    // Input is never taken while results are being drained.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    // A set end starts the drain in the next cycle.
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after set end");

    // The drain begins at rank zero.
    a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (m_tdata[VALUE_W+RANK_W-1:VALUE_W] == '0))
        else $error("drain does not start at rank zero");

    // The final beat ends the drain and reopens the input.
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("drain did not end after last result");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind streaming_top_k_selector_unit tks_checker u_tks_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
